[rtl/core/swm_pkg.sv]
// Types and constants shared by the sliding window median filter.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int CFG_W = 7;
  localparam int WINDOW_SIZE_RESET = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_size;
  } cfg_item_t;

  // Command broadcast to every node of the sorted chain.
  typedef struct packed {
    logic    en;
    logic    remove;
    sample_t sample;
    sample_t oldest;
  } upd_t;

  // Flags a node shares with its neighbours.
  typedef struct packed {
    logic keep;   // node lies before the removal point
    logic le_new; // node holds a value not above the new sample
    logic ahead;  // after removal, this position stays ahead of the new sample
  } link_t;

endpackage

[rtl/core/swm_chan_if.sv]
// Valid/ready channel carrying one item of a chosen payload type.
interface swm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/swm_node.sv]
// One position of the sorted window chain.
module swm_node
  import swm_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  upd_t             upd,
  input  logic [CNT_W-1:0] held,
  input  logic [CNT_W-1:0] kept,
  input  logic [IDX_W-1:0] lo_idx,
  input  logic [IDX_W-1:0] hi_idx,
  input  sample_t          left_value,
  input  link_t            left_link,
  input  sample_t          right_value,
  input  link_t            right_link,
  output sample_t          value,
  output link_t            link,
  output sample_t          lo_pick,
  output sample_t          hi_pick
);

  logic    occupied;
  logic    occupied_after;
  sample_t shifted;
  sample_t left_shifted;
  sample_t value_next;

  always_comb begin
    occupied       = CNT_W'(IDX) < held;
    occupied_after = CNT_W'(IDX) < kept;
    link.keep      = !upd.remove || (occupied && (value < upd.oldest));
    link.le_new    = occupied && (value <= upd.sample);
    // Value held here once the oldest sample has been taken out.
    shifted        = link.keep ? value : right_value;
    left_shifted   = left_link.keep ? left_value : value;
    link.ahead     = occupied_after && (link.keep ? link.le_new : right_link.le_new);
    if (link.ahead) begin
      value_next = shifted;
    end else if (left_link.ahead) begin
      value_next = upd.sample;
    end else begin
      value_next = left_shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      value <= value_next;
    end
  end

  assign lo_pick = (IDX_W'(IDX) == lo_idx) ? value : '0;
  assign hi_pick = (IDX_W'(IDX) == hi_idx) ? value : '0;

endmodule

[rtl/core/swm_chain.sv]
// Row of sorted window nodes and the selection of the two middle values.
module swm_chain
  import swm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  upd_t             upd,
  input  logic [CNT_W-1:0] held,
  input  logic [CNT_W-1:0] kept,
  input  logic [IDX_W-1:0] lo_idx,
  input  logic [IDX_W-1:0] hi_idx,
  output sample_t          lo_value,
  output sample_t          hi_value
);

  sample_t values   [DEPTH];
  link_t   links    [DEPTH];
  sample_t lo_picks [DEPTH];
  sample_t hi_picks [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_node
    sample_t left_value;
    link_t   left_link;
    sample_t right_value;
    link_t   right_link;

    if (j == 0) begin : g_first
      // The head of the chain sees an edge that always lies before the new sample.
      assign left_value = '0;
      assign left_link  = '{keep: 1'b1, le_new: 1'b1, ahead: 1'b1};
    end else begin : g_inner_l
      assign left_value = values[j-1];
      assign left_link  = links[j-1];
    end

    if (j == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_link  = '{keep: 1'b0, le_new: 1'b0, ahead: 1'b0};
    end else begin : g_inner_r
      assign right_value = values[j+1];
      assign right_link  = links[j+1];
    end

    swm_node #(
      .IDX   (j),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_node (
      .clk         (clk),
      .upd         (upd),
      .held        (held),
      .kept        (kept),
      .lo_idx      (lo_idx),
      .hi_idx      (hi_idx),
      .left_value  (left_value),
      .left_link   (left_link),
      .right_value (right_value),
      .right_link  (right_link),
      .value       (values[j]),
      .link        (links[j]),
      .lo_pick     (lo_picks[j]),
      .hi_pick     (hi_picks[j])
    );
  end

  // Exactly one node answers each index, the rest give zero.
  always_comb begin
    lo_value = '0;
    hi_value = '0;
    for (int j = 0; j < DEPTH; j++) begin
      lo_value = lo_value | lo_picks[j];
      hi_value = hi_value | hi_picks[j];
    end
  end

endmodule

[rtl/core/sliding_window_median.sv]
// Top level of the sliding window median filter.
//
// Channel samples takes one item per sample: a signed 32-bit sample and a
// restart flag that empties the window before the sample enters. Channel
// medians gives twice the median of the last W samples as a signed 33-bit
// value, so that the mean of two middle values stays exact. Channel
// window_cfg writes W; values of zero are taken as one and values above
// WINDOW_MAX as WINDOW_MAX, and every write empties the window.
// While the window is still filling, an item gives no result.
// Each item is handled in order: first the oldest sample is read
// from the arrival memory, then the whole sorted chain takes the
// oldest sample out and puts the new one in at once, and last the
// two middle values are picked from the chain and added into the output
// register. A new sample is taken only once the last one has left the
// final step.
// The output register parts the two sides: the next item is accepted while
// a result waits, and only the final step holds if the register is still
// full. Reset empties the window and sets W to three; no clearing pass is
// needed, as the stores are only ever used where they have been written.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input logic              clk,
  input logic              rst,
  swm_chan_if.sink         samples,
  swm_chan_if.source       medians,
  swm_chan_if.sink         window_cfg
);

  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WCMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RESET_W = (WINDOW_SIZE_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_SIZE_RESET;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_MED  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] slot;
  logic             remove;
  sample_t          sample_q;
  logic             emit;
  sample_t          arrival [WINDOW_MAX];
  sample_t          oldest;
  logic             out_valid;
  out_item_t        out_data;

  logic             accept;
  logic             cfg_write;
  logic [CNT_W-1:0] fill_eff;
  logic [IDX_W-1:0] pos_eff;
  logic             full_eff;
  logic [IDX_W-1:0] slot_next;
  logic [WCMP_W-1:0] size_ext;
  logic [WCMP_W-1:0] size_clamped;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] fill_next;
  logic [IDX_W-1:0] hi_idx;
  logic [IDX_W-1:0] lo_idx;
  logic             load_out;
  upd_t             upd;
  sample_t          lo_value;
  sample_t          hi_value;

  assign samples.ready    = (state == ST_IDLE);
  assign window_cfg.ready = 1'b1;
  assign accept           = samples.valid && samples.ready;
  assign cfg_write        = window_cfg.valid && window_cfg.ready;

  // A restart counts from an empty window straight away.
  always_comb begin
    fill_eff  = samples.data.restart ? '0 : fill;
    pos_eff   = samples.data.restart ? '0 : pos;
    full_eff  = fill_eff >= w_eff;
    slot_next = full_eff ? pos_eff : IDX_W'(fill_eff);
  end

  always_comb begin
    size_ext = WCMP_W'(window_cfg.data.window_size);
    if (size_ext == '0) begin
      size_clamped = WCMP_W'(1);
    end else if (size_ext > WCMP_W'(WINDOW_MAX)) begin
      size_clamped = WCMP_W'(WINDOW_MAX);
    end else begin
      size_clamped = size_ext;
    end
  end

  // Middle positions of the sorted window; they coincide for an odd size.
  always_comb begin
    hi_idx = IDX_W'(w_eff >> 1);
    lo_idx = w_eff[0] ? hi_idx : IDX_W'((w_eff >> 1) - CNT_W'(1));
  end

  always_comb begin
    kept       = remove ? fill - CNT_W'(1) : fill;
    fill_next  = kept + CNT_W'(1);
    upd.en     = (state == ST_UPD);
    upd.remove = remove;
    upd.sample = sample_q;
    upd.oldest = oldest;
  end

  assign load_out = (state == ST_MED) && emit && (!out_valid || medians.ready);

  // Arrival history: read at acceptance, written during the chain update.
  always_ff @(posedge clk) begin
    if (accept) begin
      oldest <= arrival[slot_next];
    end
    if (state == ST_UPD) begin
      arrival[slot] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samples.data.sample;
      slot     <= slot_next;
      remove   <= full_eff;
    end
    if (state == ST_UPD) begin
      emit <= fill_next >= w_eff;
    end
    if (load_out) begin
      out_data.median_doubled <= {lo_value[SAMPLE_W-1], lo_value}
                               + {hi_value[SAMPLE_W-1], hi_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      w_eff     <= CNT_W'(RESET_W);
      fill      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fill  <= fill_eff;
            pos   <= pos_eff;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          fill <= fill_next;
          if (remove) begin
            pos <= (CNT_W'(slot) + CNT_W'(1) == w_eff) ? '0 : slot + IDX_W'(1);
          end
          state <= ST_MED;
        end
        ST_MED: begin
          if (!emit || load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_write) begin
        w_eff <= CNT_W'(size_clamped);
        fill  <= '0;
        pos   <= '0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (medians.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign medians.valid = out_valid;
  assign medians.data  = out_data;

  swm_chain #(
    .DEPTH (WINDOW_MAX),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk      (clk),
    .upd      (upd),
    .held     (fill),
    .kept     (kept),
    .lo_idx   (lo_idx),
    .hi_idx   (hi_idx),
    .lo_value (lo_value),
    .hi_value (hi_value)
  );

endmodule
